// ===== design/tss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Topological sort package
// Shared types and constants for the stack-based topological sort core.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int NODE_W = 5;
    localparam int CFG_W  = 6;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SEED,
        ST_POP,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clr;
        logic push;
        logic pop;
    } t_stk_ctrl;

endpackage
`default_nettype wire

// ===== design/topological_sort_stack_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Add-edge and clear beats update the matrix as they are accepted.
// A sort over n nodes counts in-degrees, seeds the ready stack, then per node
// pops one node, scans all n candidate successors and emits it; an empty run
// emits a single beat with valid_res low.
// One beat at a time: input not ready while a sort is running.
// Reset: adjacency matrix cleared, node_count 32, output empty.
// ----------------------------------------------------------------------------
// Topological sort core
// Adjacency bit matrix with Kahn's sort driven by a LIFO ready stack.
// ----------------------------------------------------------------------------
module topological_sort_stack_core #(
    parameter int MAX_NODES = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [15:0]                  s_axis_tdata,  // from_node[4:0], to_node[9:5]
    input  wire  [1:0]                   s_axis_tuser,  // mode[1:0]
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [7:0]                   m_axis_tdata,  // node_index[4:0]
    output logic [0:0]                   m_axis_tuser,  // valid_res[0]
    output logic                         m_axis_tlast,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [tss_pkg::CFG_W-1:0]    i_cfg_data     // node_count[5:0]
);
    import tss_pkg::*;

    localparam int NODES = (MAX_NODES < 32) ? MAX_NODES : 32;
    localparam int NW    = $clog2(NODES);
    localparam int CW    = $clog2(NODES + 1);

    logic [CFG_W-1:0]  r_node_count;
    logic [NODES-1:0]  r_adj   [NODES];
    logic [CW-1:0]     r_indeg [NODES];

    t_state            r_state, n_state;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_n;
    logic [NW-1:0]     r_v, n_v;
    logic              r_empty, n_empty;

    logic              r_out_valid;
    logic [NODE_W-1:0] r_out_node;
    logic              r_out_vres;
    logic              r_out_last;

    logic              in_acc;
    logic [1:0]        in_mode;
    logic [NODE_W-1:0] in_from, in_to;
    logic              in_range;
    logic [CW-1:0]     run_n;

    logic [NW-1:0]     rd_addr;
    logic [NODES-1:0]  rd_row;
    logic [NODES-1:0]  col_mask;
    logic [NODES-1:0]  row_m;
    logic [CW-1:0]     cur_deg;
    logic [CW-1:0]     dec_deg;
    logic              edge_hit;
    logic              idx_end;

    t_stk_ctrl         stk;
    logic [NW-1:0]     stk_top;
    logic [CW-1:0]     stk_count;
    logic              stk_empty;

    logic              cnt_add, indeg_clr, indeg_wr, out_load;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_mode  = s_axis_tuser;
    assign in_from  = s_axis_tdata[4:0];
    assign in_to    = s_axis_tdata[9:5];
    assign in_range = (int'(in_from) < NODES) && (int'(in_to) < NODES);
    assign run_n    = (int'(r_node_count) > NODES) ? CW'(NODES) : CW'(r_node_count);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CFG_W'(32);
        end else if (i_cfg_valid) begin
            r_node_count <= i_cfg_data;
        end
    end

    // adjacency matrix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NODES; r++) begin
                r_adj[r] <= '0;
            end
        end else if (in_acc && (in_mode == MODE_CLEAR)) begin
            for (int r = 0; r < NODES; r++) begin
                r_adj[r] <= '0;
            end
        end else if (in_acc && (in_mode == MODE_ADD) && in_range) begin
            r_adj[in_from[NW-1:0]][in_to[NW-1:0]] <= 1'b1;
        end
    end

    assign rd_addr = (r_state == ST_SCAN) ? r_v : r_idx[NW-1:0];
    assign rd_row  = r_adj[rd_addr];

    always_comb begin
        for (int j = 0; j < NODES; j++) begin
            col_mask[j] = (CW'(j) < r_n);
        end
    end

    assign row_m    = rd_row & col_mask;
    assign cur_deg  = r_indeg[r_idx[NW-1:0]];
    assign dec_deg  = (cur_deg != '0) ? (cur_deg - 1'b1) : '0;
    assign edge_hit = rd_row[r_idx[NW-1:0]];
    assign idx_end  = (r_idx == CW'(r_n - 1'b1));

    always_ff @(posedge i_clk) begin
        if (indeg_clr) begin
            for (int j = 0; j < NODES; j++) begin
                r_indeg[j] <= '0;
            end
        end else if (cnt_add) begin
            for (int j = 0; j < NODES; j++) begin
                r_indeg[j] <= r_indeg[j] + CW'(row_m[j]);
            end
        end else if (indeg_wr) begin
            r_indeg[r_idx[NW-1:0]] <= dec_deg;
        end
    end

    tss_stack #(
        .DEPTH (NODES),
        .DW    (NW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (stk),
        .i_data  (r_idx[NW-1:0]),
        .o_top   (stk_top),
        .o_count (stk_count),
        .o_empty (stk_empty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_n     <= '0;
            r_v     <= '0;
            r_empty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_v     <= n_v;
            r_empty <= n_empty;
            if (in_acc && (in_mode == MODE_RUN)) begin
                r_n <= run_n;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_v       = r_v;
        n_empty   = r_empty;
        stk       = '0;
        cnt_add   = 1'b0;
        indeg_clr = 1'b0;
        indeg_wr  = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (in_mode == MODE_RUN)) begin
                    indeg_clr = 1'b1;
                    stk.clr   = 1'b1;
                    n_idx     = '0;
                    n_state   = (run_n == '0) ? ST_POP : ST_COUNT;
                end
            end
            ST_COUNT: begin
                cnt_add = 1'b1;
                if (idx_end) begin
                    n_idx   = '0;
                    n_state = ST_SEED;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_SEED: begin
                stk.push = (cur_deg == '0);
                if (idx_end) begin
                    n_idx   = '0;
                    n_state = ST_POP;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_POP: begin
                if (stk_empty) begin
                    n_empty = 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    stk.pop = 1'b1;
                    n_v     = stk_top;
                    n_empty = 1'b0;
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (edge_hit) begin
                    indeg_wr = 1'b1;
                    stk.push = (r_idx[NW-1:0] != r_v) && (dec_deg == '0);
                end
                if (idx_end) begin
                    n_state = ST_EMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = (r_empty || stk_empty) ? ST_IDLE : ST_POP;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_node <= r_empty ? '0 : NODE_W'(r_v);
            r_out_vres <= !r_empty;
            r_out_last <= r_empty || stk_empty;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_node};
    assign m_axis_tuser  = r_out_vres;
    assign m_axis_tlast  = r_out_last;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("empty-run beat without tlast");
    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_COUNT) || (r_state == ST_SEED) || (r_state == ST_SCAN))
        |-> (r_idx < r_n))
        else $error("scan index beyond run size");
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (stk_count <= r_n))
        else $error("ready stack deeper than run size");
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_empty || stk_empty)) |=> (r_state == ST_IDLE))
        else $error("run did not finish after last beat");

endmodule
`default_nettype wire

// ===== design/tss_stack.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ready stack
// LIFO of node indices with clear, push and pop; top entry read directly.
// ----------------------------------------------------------------------------
module tss_stack #(
    parameter int DEPTH = 32,
    parameter int DW    = 5
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  tss_pkg::t_stk_ctrl     i_ctrl,
    input  wire  [DW-1:0]                i_data,
    output logic [DW-1:0]                o_top,
    output logic [$clog2(DEPTH+1)-1:0]   o_count,
    output logic                         o_empty
);
    import tss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        priority if (i_ctrl.clr) begin
            n_cnt = '0;
        end else if (i_ctrl.push && (r_cnt < CW'(DEPTH))) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_ctrl.pop && (r_cnt != '0)) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && !i_ctrl.clr && (r_cnt < CW'(DEPTH))) begin
            r_mem[r_cnt[AW-1:0]] <= i_data;
        end
    end

    assign o_top   = r_mem[AW'(r_cnt - 1'b1)];
    assign o_count = r_cnt;
    assign o_empty = (r_cnt == '0);

    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctrl.push && i_ctrl.pop))
        else $error("stack push and pop in one cycle");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.push |-> (r_cnt < CW'(DEPTH)))
        else $error("stack overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.pop |-> (r_cnt != '0))
        else $error("stack underflow");
    a_clr_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clr |=> (r_cnt == '0))
        else $error("stack not empty after clear");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Topological sort core testbench
// Queue-fed stream driver and clocked monitor around topological_sort_stack_core.
// A local copy of the adjacency matrix and node count predicts each sort.
// Every output beat is checked field by field against the oldest prediction.
// Directed corner cases run first, then randomised graph runs. Sender and
// receiver back-pressure vary by phase.
// ----------------------------------------------------------------------------
module tb;
    import tss_pkg::*;

    localparam int          NODES       = 32;
    localparam int          SETTLE      = 16;
    localparam int          BEAT_TARGET = 210;
    localparam logic [1:0]  MODE_SPARE  = 2'd3;

    typedef enum logic [1:0] {
        SK_BEAT,
        SK_CFG,
        SK_DRAIN,
        SK_PHASE
    } t_stim_kind;

    typedef struct {
        t_stim_kind   kind;
        logic [1:0]   mode;
        logic [4:0]   from_node;
        logic [4:0]   to_node;
        logic [5:0]   count;
        int           send_pct;
        int           recv_pct;
    } t_stim;

    typedef struct packed {
        logic [4:0] node;
        logic       valid_res;
        logic       last;
    } t_order_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [5:0]  i_cfg_data = '0;

    t_stim       stim_q [$];
    t_order_beat order_q [$];

    logic [31:0] graph [NODES];
    logic [5:0]  node_cnt;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          errors = 0;
    int          beats_queued = 0;

    t_stim       held;
    logic        send_hold;
    logic        cfg_hold;
    int          quiet = 0;

    topological_sort_stack_core #(
        .MAX_NODES(NODES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Kahn's sort over the local matrix, LIFO ready stack
    task automatic kahn_order();
        int          n;
        int          depth;
        int          v;
        int          deg [NODES];
        logic [4:0]  stk [64];
        t_order_beat res [$];
        t_order_beat r;
        n = (node_cnt > 6'(NODES)) ? NODES : int'(node_cnt);
        depth = 0;
        for (int i = 0; i < n; i++) begin
            deg[i] = 0;
            for (int k = 0; k < n; k++) if (graph[k][i]) deg[i]++;
        end
        for (int i = 0; i < n; i++) begin
            if (deg[i] == 0) begin
                stk[depth] = 5'(i);
                depth++;
            end
        end
        while (depth > 0 && res.size() < 32) begin
            depth--;
            v = int'(stk[depth]);
            r.node = 5'(v);
            r.valid_res = 1'b1;
            r.last = 1'b0;
            res.push_back(r);
            for (int i = 0; i < n; i++) begin
                if (graph[v][i]) begin
                    if (deg[i] > 0) deg[i]--;
                    if (i != v && deg[i] == 0 && depth < 64) begin
                        stk[depth] = 5'(i);
                        depth++;
                    end
                end
            end
        end
        if (res.size() == 0) begin
            r.node = '0;
            r.valid_res = 1'b0;
            r.last = 1'b1;
            res.push_back(r);
        end else begin
            res[res.size() - 1].last = 1'b1;
        end
        foreach (res[j]) order_q.push_back(res[j]);
    endtask

    task automatic apply_beat(input t_stim b);
        case (b.mode)
            MODE_ADD:   graph[b.from_node][b.to_node] = 1'b1;
            MODE_RUN:   kahn_order();
            MODE_CLEAR: foreach (graph[f]) graph[f] = '0;
            default: ;
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (graph[f]) graph[f] = '0;
            node_cnt = 6'd32;
            s_axis_tvalid <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            send_hold = s_axis_tvalid;
            cfg_hold = i_cfg_valid;
            if (s_axis_tvalid && s_axis_tready) begin
                apply_beat(held);
                send_hold = 1'b0;
                quiet = 0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                node_cnt = i_cfg_data;
                cfg_hold = 1'b0;
            end
            if (order_q.size() != 0 || send_hold) quiet = 0;
            else if (quiet < 1000) quiet++;
            if (!send_hold && !cfg_hold && stim_q.size() != 0) begin
                case (stim_q[0].kind)
                    SK_BEAT: begin
                        if ($urandom_range(99) >= send_idle) begin
                            held = stim_q.pop_front();
                            s_axis_tdata <= {6'd0, held.to_node, held.from_node};
                            s_axis_tuser <= held.mode;
                            send_hold = 1'b1;
                        end
                    end
                    SK_CFG: begin
                        if (quiet >= SETTLE) begin
                            held = stim_q.pop_front();
                            i_cfg_data <= held.count;
                            cfg_hold = 1'b1;
                        end
                    end
                    SK_DRAIN: begin
                        if (order_q.size() == 0) void'(stim_q.pop_front());
                    end
                    SK_PHASE: begin
                        held = stim_q.pop_front();
                        send_idle <= held.send_pct;
                        recv_idle <= held.recv_pct;
                    end
                    default: ;
                endcase
            end
            s_axis_tvalid <= send_hold;
            i_cfg_valid <= cfg_hold;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_order_beat want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (order_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat node_index %0d",
                                            m_axis_tdata[4:0]));
                end else begin
                    want = order_q.pop_front();
                    if (m_axis_tdata[4:0] !== want.node)
                        note_mismatch($sformatf("node_index got %0d want %0d",
                                                m_axis_tdata[4:0], want.node));
                    if (m_axis_tuser[0] !== want.valid_res)
                        note_mismatch($sformatf("valid_res got %b want %b",
                                                m_axis_tuser[0], want.valid_res));
                    if (m_axis_tlast !== want.last)
                        note_mismatch($sformatf("last got %b want %b",
                                                m_axis_tlast, want.last));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic push_beat(input logic [1:0] mode, input logic [4:0] f,
                             input logic [4:0] t);
        t_stim s;
        s.kind = SK_BEAT;
        s.mode = mode;
        s.from_node = f;
        s.to_node = t;
        stim_q.push_back(s);
        if (mode != MODE_SPARE) beats_queued++;
    endtask

    task automatic push_cfg(input logic [5:0] v);
        t_stim s;
        s.kind = SK_CFG;
        s.count = v;
        stim_q.push_back(s);
    endtask

    task automatic push_marker(input t_stim_kind k, input int sp, input int rp);
        t_stim s;
        s.kind = k;
        s.send_pct = sp;
        s.recv_pct = rp;
        stim_q.push_back(s);
    endtask

    // mostly clear, random DAG (plus the odd cycle, self-loop or stray edge), sort; else random beats, sort
    task automatic graph_run(inout logic [5:0] cur_cnt);
        int pick;
        int n;
        int span;
        int e;
        int a;
        int b;
        int tmp;
        int perm [NODES];
        pick = $urandom_range(99);
        if (pick < 35) begin
            if (pick < 5)       cur_cnt = 6'd0;
            else if (pick < 10) cur_cnt = 6'($urandom_range(33, 63));
            else if (pick < 17) cur_cnt = 6'd32;
            else                cur_cnt = 6'($urandom_range(1, 12));
            push_cfg(cur_cnt);
        end
        n = (cur_cnt > 6'd32) ? 32 : int'(cur_cnt);
        span = (n < 2) ? 2 : n;
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(3, 7))
                push_beat(2'($urandom_range(3)), 5'($urandom), 5'($urandom));
            push_beat(MODE_RUN, 5'($urandom), 5'($urandom));
            return;
        end
        if ($urandom_range(99) < 85) push_beat(MODE_CLEAR, 5'($urandom), 5'($urandom));
        for (int i = 0; i < NODES; i++) perm[i] = i;
        for (int i = span - 1; i > 0; i--) begin
            a = $urandom_range(i);
            tmp = perm[i];
            perm[i] = perm[a];
            perm[a] = tmp;
        end
        e = $urandom_range(0, (2 * span > 18) ? 18 : 2 * span);
        repeat (e) begin
            a = $urandom_range(span - 2);
            b = $urandom_range(a + 1, span - 1);
            pick = $urandom_range(99);
            if (pick < 8)
                push_beat(MODE_ADD, 5'($urandom), 5'($urandom));
            else if (pick < 13)
                push_beat(MODE_ADD, 5'(perm[b]), 5'(perm[a]));
            else if (pick < 16)
                push_beat(MODE_ADD, 5'(perm[a]), 5'(perm[a]));
            else
                push_beat(MODE_ADD, 5'(perm[a]), 5'(perm[b]));
        end
        push_beat(MODE_RUN, 5'($urandom), 5'($urandom));
        if ($urandom_range(99) < 20) push_beat(MODE_RUN, 5'($urandom), 5'($urandom));
    endtask

    initial begin
        logic [5:0] cur_cnt;
        int         phase;
        cur_cnt = 6'd32;
        phase = 1;

        push_marker(SK_PHASE, 25, 71);
        // empty matrix: every node ready, emitted in descending order
        push_beat(MODE_RUN, 5'd0, 5'd0);
        push_beat(MODE_SPARE, 5'd31, 5'd31);
        push_beat(MODE_ADD, 5'd0, 5'd31);
        push_beat(MODE_ADD, 5'd31, 5'd0);
        push_beat(MODE_ADD, 5'd5, 5'd5);
        push_beat(MODE_ADD, 5'd0, 5'd1);
        push_beat(MODE_ADD, 5'd3, 5'd7);
        push_beat(MODE_RUN, 5'd31, 5'd31);
        push_cfg(6'd0);
        push_beat(MODE_RUN, 5'd0, 5'd0);
        push_cfg(6'd63);
        push_beat(MODE_RUN, 5'd0, 5'd0);
        push_cfg(6'd1);
        push_beat(MODE_RUN, 5'd0, 5'd0);
        push_cfg(6'd3);
        push_beat(MODE_ADD, 5'd2, 5'd20);
        push_beat(MODE_RUN, 5'd0, 5'd0);
        push_beat(MODE_CLEAR, 5'd31, 5'd31);
        push_beat(MODE_RUN, 5'd0, 5'd0);
        push_cfg(6'd2);
        push_beat(MODE_ADD, 5'd0, 5'd1);
        push_beat(MODE_ADD, 5'd1, 5'd0);
        push_beat(MODE_RUN, 5'd0, 5'd0);
        push_cfg(6'd32);

        while (beats_queued < BEAT_TARGET) begin
            if (phase == 1 && beats_queued >= BEAT_TARGET / 3) begin
                push_marker(SK_DRAIN, 0, 0);
                push_marker(SK_PHASE, 71, 25);
                phase = 2;
            end else if (phase == 2 && beats_queued >= 2 * BEAT_TARGET / 3) begin
                push_marker(SK_DRAIN, 0, 0);
                push_marker(SK_PHASE, 0, 0);
                phase = 3;
            end
            graph_run(cur_cnt);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || s_axis_tvalid || i_cfg_valid || order_q.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (errors == 0 && order_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
